@@ hdl/aap_pkg.sv @@
// ----------------------------------------------------------------------------
// aap_pkg
// Shared types, sizes and helpers for the adaptive average pooling block.
// ----------------------------------------------------------------------------
package aap_pkg;

  localparam int MaxInDim  = 256;
  localparam int MaxOutDim = 8;
  localparam int NumCells  = MaxOutDim * MaxOutDim;
  localparam int DimW      = $clog2(MaxInDim + 1);   // 9 bits: 1..256
  localparam int OdimW     = $clog2(MaxOutDim + 1);  // 4 bits: 1..8
  localparam int IdxW      = $clog2(MaxOutDim);      // 3 bits
  localparam int SumW      = 32;
  localparam int AreaW     = 2 * DimW - 1;           // up to 65536
  localparam int PixW      = 16;
  localparam int RecipSh   = 12;
  localparam int RecipW    = RecipSh + 1;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 9;
  localparam int SettleCyc = 5;

  typedef enum logic [CfgAddrW-1:0] {
    REG_IN_HEIGHT  = 3'd0,
    REG_IN_WIDTH   = 3'd1,
    REG_OUT_HEIGHT = 3'd2,
    REG_OUT_WIDTH  = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_PUT
  } aap_state_t;

  // per-item control broadcast to the accumulator cells
  typedef struct packed {
    logic accept;  // a pixel is taken this cycle
    logic first;   // pixel is at row 0, column 0: restart the sum
  } cell_ctrl_t;

  // floor(4096 / d) for d = 1..8, used to divide a size by an output size
  function automatic logic [RecipW-1:0] recip(input logic [OdimW-1:0] d);
    logic [RecipW-1:0] v;
    unique case (d)
      4'd1:    v = 13'd4096;
      4'd2:    v = 13'd2048;
      4'd3:    v = 13'd1365;
      4'd4:    v = 13'd1024;
      4'd5:    v = 13'd819;
      4'd6:    v = 13'd682;
      4'd7:    v = 13'd585;
      default: v = 13'd512;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/aap_cell.sv @@
// ----------------------------------------------------------------------------
// aap_cell
// One window accumulator: adds the pixel when its window holds it.
// ----------------------------------------------------------------------------
module aap_cell import aap_pkg::*; (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic                   hit,
  input  logic signed [PixW-1:0] pixel,
  output logic        [SumW-1:0] sum
);

  logic [SumW-1:0] sum_r;
  logic [SumW-1:0] sum_nxt;
  logic [SumW-1:0] addend;

  always_comb begin
    addend  = hit ? SumW'(pixel) : '0;
    sum_nxt = sum_r;
    if (ctrl.accept) begin
      sum_nxt = (ctrl.first ? '0 : sum_r) + addend;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

@@ hdl/aap_div.sv @@
// ----------------------------------------------------------------------------
// aap_div
// Signed sum over unsigned area, one quotient bit a cycle, truncates to zero.
// ----------------------------------------------------------------------------
module aap_div import aap_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SumW-1:0]        dividend,
  input  logic [AreaW-1:0]       divisor,
  output logic                   done,
  output logic [PixW-1:0]        quotient
);

  localparam int CntW = $clog2(SumW);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt;
  logic [SumW-1:0]   num_r, num_nxt;
  logic [AreaW:0]    rem_r, rem_nxt;
  logic [AreaW-1:0]  den_r, den_nxt;
  logic [AreaW+1:0]  trial;
  logic [AreaW:0]    shifted;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    shifted  = {rem_r[AreaW-1:0], num_r[SumW-1]};
    trial    = {1'b0, shifted} - {2'b00, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[SumW-1];
      num_nxt  = dividend[SumW-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (!trial[AreaW+1]) begin
        rem_nxt = trial[AreaW:0];
        num_nxt = {num_r[SumW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        num_nxt = {num_r[SumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(SumW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~num_r[PixW-1:0] + 1'b1) : num_r[PixW-1:0];

endmodule

@@ hdl/adaptive_average_pool_2d.sv @@
// ----------------------------------------------------------------------------
// adaptive_average_pool_2d
// Adaptive average pooling of one plane; pixels arrive in raster order.
// ----------------------------------------------------------------------------
// Sequence: a pixel that closes a window moves the sequencer to ST_LOAD, which
//   starts the divider; ST_DIV waits while it forms the quotient bit by bit, and
//   ST_PUT loads the output register once out_stall lets it.
// Throughput: one pixel a cycle when it closes no window and sizes have settled;
//   a closing pixel holds the input until its mean is loaded for output.
// Reset: synchronous, active low; sizes to 8x8 -> 1x1, scan position to zero. After
//   reset or any write to a size register the input stalls while sizes settle.
module adaptive_average_pool_2d import aap_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [PixW-1:0] in_pixel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [PixW-1:0] out_mean,
  output logic [IdxW-1:0]        out_out_row,
  output logic [IdxW-1:0]        out_out_col,
  output logic                   out_plane_done,
  input  logic                   cfg_we,
  input  logic [CfgAddrW-1:0]    cfg_addr,
  input  logic [CfgDataW-1:0]    cfg_wdata
);

  // configuration registers
  logic [DimW-1:0]  in_h_r, in_w_r;
  logic [OdimW-1:0] out_h_r, out_w_r;
  logic             cfg_hit;
  logic [2:0]       settle_r, settle_nxt;

  // size pipeline: clamp, estimate stride, correct, window, area
  logic [DimW-1:0]  ih1_r, iw1_r, sh3_r, sw3_r, ph4_r, pw4_r;
  logic [OdimW-1:0] oh1_r, ow1_r;
  logic [DimW:0]    qh2_r, qw2_r;
  logic [AreaW-1:0] area5_r;
  logic [DimW-1:0]  ih_c, iw_c;
  logic [OdimW-1:0] oh_c, ow_c;

  // scan position and handshake state
  logic [DimW-1:0]  y_r, x_r, y_nxt, x_nxt;
  aap_state_t       state_r, state_nxt;
  logic             accept;
  cell_ctrl_t       ctrl;

  logic [MaxOutDim-1:0] rhit, rdone, chit, cdone;
  logic [IdxW-1:0]      dr, dc;
  logic [IdxW-1:0]      dr_r, dc_r;
  logic                 last_r;
  logic [SumW-1:0]      sums [NumCells];
  logic [SumW-1:0]      sel_sum;
  logic                 div_start, div_done;
  logic [PixW-1:0]      quot;

  logic                 out_valid_r, out_valid_nxt;
  logic [PixW-1:0]      mean_r;
  logic [IdxW-1:0]      orow_r, ocol_r;
  logic                 odone_r;
  logic                 load_out;

  assign cfg_hit = cfg_we && (cfg_addr == REG_IN_HEIGHT || cfg_addr == REG_IN_WIDTH ||
                              cfg_addr == REG_OUT_HEIGHT || cfg_addr == REG_OUT_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_h_r  <= DimW'(8);
      in_w_r  <= DimW'(8);
      out_h_r <= OdimW'(1);
      out_w_r <= OdimW'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_IN_HEIGHT:  in_h_r  <= cfg_wdata;
        REG_IN_WIDTH:   in_w_r  <= cfg_wdata;
        REG_OUT_HEIGHT: out_h_r <= cfg_wdata[OdimW-1:0];
        REG_OUT_WIDTH:  out_w_r <= cfg_wdata[OdimW-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes; output size never above input size
  always_comb begin
    ih_c = (in_h_r == '0) ? DimW'(1) : (in_h_r > DimW'(MaxInDim)) ? DimW'(MaxInDim) : in_h_r;
    iw_c = (in_w_r == '0) ? DimW'(1) : (in_w_r > DimW'(MaxInDim)) ? DimW'(MaxInDim) : in_w_r;
    oh_c = (out_h_r == '0) ? OdimW'(1)
         : (out_h_r > OdimW'(MaxOutDim)) ? OdimW'(MaxOutDim) : out_h_r;
    ow_c = (out_w_r == '0) ? OdimW'(1)
         : (out_w_r > OdimW'(MaxOutDim)) ? OdimW'(MaxOutDim) : out_w_r;
    if (DimW'(oh_c) > ih_c) oh_c = ih_c[OdimW-1:0];
    if (DimW'(ow_c) > iw_c) ow_c = iw_c[OdimW-1:0];
  end

  // stride = in / out via reciprocal; estimate is exact or one low
  always_ff @(posedge clk) begin
    ih1_r <= ih_c;
    iw1_r <= iw_c;
    oh1_r <= oh_c;
    ow1_r <= ow_c;
    qh2_r <= (DimW+1)'(({{RecipW{1'b0}}, ih1_r} * {{DimW{1'b0}}, recip(oh1_r)}) >> RecipSh);
    qw2_r <= (DimW+1)'(({{RecipW{1'b0}}, iw1_r} * {{DimW{1'b0}}, recip(ow1_r)}) >> RecipSh);
    sh3_r <= DimW'(qh2_r) +
             DimW'(((qh2_r + 1'b1) * {{(DimW-OdimW+1){1'b0}}, oh1_r}) <= {1'b0, ih1_r});
    sw3_r <= DimW'(qw2_r) +
             DimW'(((qw2_r + 1'b1) * {{(DimW-OdimW+1){1'b0}}, ow1_r}) <= {1'b0, iw1_r});
    ph4_r <= ih1_r - DimW'(sh3_r * DimW'(oh1_r - 1'b1));
    pw4_r <= iw1_r - DimW'(sw3_r * DimW'(ow1_r - 1'b1));
    area5_r <= AreaW'(ph4_r) * AreaW'(pw4_r);
  end

  always_comb begin
    settle_nxt = settle_r;
    if (cfg_hit) begin
      settle_nxt = 3'(SettleCyc);
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - 1'b1;
    end
  end

  // window hits per output row and column
  always_comb begin
    logic [DimW+IdxW-1:0] r0, c0;
    rhit = '0;
    rdone = '0;
    chit = '0;
    cdone = '0;
    for (int i = 0; i < MaxOutDim; i++) begin
      r0 = (DimW+IdxW)'(i) * (DimW+IdxW)'(sh3_r);
      c0 = (DimW+IdxW)'(i) * (DimW+IdxW)'(sw3_r);
      rhit[i]  = (OdimW'(i) < oh1_r) && ((DimW+IdxW)'(y_r) >= r0) &&
                 ((DimW+IdxW)'(y_r) < r0 + (DimW+IdxW)'(ph4_r));
      rdone[i] = rhit[i] && ((DimW+IdxW)'(y_r) == r0 + (DimW+IdxW)'(ph4_r) - 1'b1);
      chit[i]  = (OdimW'(i) < ow1_r) && ((DimW+IdxW)'(x_r) >= c0) &&
                 ((DimW+IdxW)'(x_r) < c0 + (DimW+IdxW)'(pw4_r));
      cdone[i] = chit[i] && ((DimW+IdxW)'(x_r) == c0 + (DimW+IdxW)'(pw4_r) - 1'b1);
    end
    dr = '0;
    dc = '0;
    for (int i = 0; i < MaxOutDim; i++) begin
      if (rdone[i]) dr = IdxW'(i);
      if (cdone[i]) dc = IdxW'(i);
    end
  end

  assign in_stall    = !(state_r == ST_IDLE && settle_r == '0);
  assign accept      = in_valid && !in_stall;
  assign ctrl.accept = accept;
  assign ctrl.first  = (y_r == '0) && (x_r == '0);

  // accumulator array, one cell per output position
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    aap_cell u_cell (
      .clk   (clk),
      .ctrl  (ctrl),
      .hit   (rhit[g / MaxOutDim] && chit[g % MaxOutDim]),
      .pixel (in_pixel),
      .sum   (sums[g])
    );
  end

  assign sel_sum = sums[{dr_r, dc_r}];

  // raster position, wraps at the plane end and clears on a size register write
  always_comb begin
    y_nxt = y_r;
    x_nxt = x_r;
    if (cfg_hit) begin
      y_nxt = '0;
      x_nxt = '0;
    end else if (accept) begin
      if (x_r + 1'b1 >= iw1_r) begin
        x_nxt = '0;
        y_nxt = (y_r + 1'b1 >= ih1_r) ? '0 : y_r + 1'b1;
      end else begin
        x_nxt = x_r + 1'b1;
      end
    end
  end

  // item sequencer and output register
  always_comb begin
    state_nxt     = state_r;
    div_start     = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (|rdone) && (|cdone)) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_PUT;
      end
      ST_PUT: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      settle_r    <= 3'(SettleCyc);
      y_r         <= '0;
      x_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      settle_r    <= settle_nxt;
      y_r         <= y_nxt;
      x_r         <= x_nxt;
    end
    if (accept) begin
      dr_r   <= dr;
      dc_r   <= dc;
      last_r <= (y_r == ih1_r - 1'b1) && (x_r == iw1_r - 1'b1);
    end
    if (load_out) begin
      mean_r  <= quot;
      orow_r  <= dr_r;
      ocol_r  <= dc_r;
      odone_r <= last_r;
    end
  end

  aap_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sel_sum),
    .divisor  (area5_r),
    .done     (div_done),
    .quotient (quot)
  );

  assign out_valid      = out_valid_r;
  assign out_mean       = mean_r;
  assign out_out_row    = orow_r;
  assign out_out_col    = ocol_r;
  assign out_plane_done = odone_r;

`ifndef NO_ASSERTIONS
  // the divider only finishes while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider result out of sequence");
  // a held result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(mean_r))
    else $error("output overwritten while stalled");
  // no pixel taken while sizes are settling
  a_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r != '0) |-> !accept) else $error("pixel taken before sizes settled");
  // at most one row and one column close per pixel
  a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(rdone) && $onehot0(cdone)) else $error("multiple windows close");
`endif

endmodule
